### src/bfir_pkg.sv
// ----------------------------------------------------------------------------
// bfir_pkg: shared types and constants of the banked FIR filter
// Field widths, default sizes, item codes, sequencer states and the
// request/result payload structs used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfir_pkg;

  // Default sizes handed to the top level
  localparam int unsigned DEF_TAPS  = 64;
  localparam int unsigned DEF_BANKS = 4;

  // Fixed field widths
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned Q_SHIFT = 15;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned IDX_W   = 6;

  // Request kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_e;

  // Input request payload
  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] sample_in;
    logic [SEL_W-1:0]         coef_bank;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] coef_value;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic signed [DATA_W-1:0] sample_out;
  } out_rsp_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator for a new sample
    logic vld;    // operand registers hold a tap this cycle
    logic live;   // tap lies inside the filled part of the delay line
  } mac_ctrl_t;

endpackage

`default_nettype wire

### src/bfir_in_if.sv
// ----------------------------------------------------------------------------
// bfir_in_if: request channel of the banked FIR filter
// Valid/ready channel carrying one sample or coefficient request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfir_in_if;
  import bfir_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### src/bfir_out_if.sv
// ----------------------------------------------------------------------------
// bfir_out_if: result channel of the banked FIR filter
// Valid/ready channel carrying one filtered sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfir_out_if;
  import bfir_pkg::*;

  logic     valid;
  logic     ready;
  out_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### src/bfir_coef_mem.sv
// ----------------------------------------------------------------------------
// bfir_coef_mem: coefficient store
// One memory holding every bank, addressed {bank, tap}; one write port and
// one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfir_coef_mem #(
  parameter int unsigned ADDR_W = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [ADDR_W-1:0]            waddr_i,
  input  wire logic [bfir_pkg::DATA_W-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0]            raddr_i,
  output logic      [bfir_pkg::DATA_W-1:0]  rdata_o
);
  import bfir_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write on request, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bfir_delay_line.sv
// ----------------------------------------------------------------------------
// bfir_delay_line: sample delay line
// Circular buffer in a memory, newest sample at the head pointer and older
// ones at rising addresses. A fill count stands in for the reset to zero:
// taps at or beyond it have never been written.
// ----------------------------------------------------------------------------
`default_nettype none

module bfir_delay_line #(
  parameter int unsigned TAPS = bfir_pkg::DEF_TAPS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push_i,
  input  wire logic [bfir_pkg::DATA_W-1:0]          push_data_i,
  input  wire logic                                 step_i,
  output logic      [bfir_pkg::DATA_W-1:0]          rd_data_o,
  output logic      [$clog2(TAPS+1)-1:0]            fill_o
);
  import bfir_pkg::*;

  localparam int unsigned TAP_W = $clog2(TAPS);
  localparam int unsigned CNT_W = $clog2(TAPS+1);
  localparam logic [TAP_W-1:0] LAST = TAP_W'(TAPS - 1);

  logic [DATA_W-1:0] mem_q [TAPS];
  logic [DATA_W-1:0] rd_data_q;
  logic [TAP_W-1:0]  head_q, head_d, head_dec;
  logic [TAP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;

  // Pointer arithmetic with wrap at TAPS
  always_comb begin
    head_dec = (head_q == '0) ? LAST : head_q - 1'b1;
    head_d   = push_i ? head_dec : head_q;
    fill_d   = fill_q;
    if (push_i && (fill_q != CNT_W'(TAPS))) begin
      fill_d = fill_q + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      rd_ptr_d = head_dec;
    end else if (step_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  // Hold pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      head_q   <= head_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the new sample, read the tap under the read pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[head_dec] <= push_data_i;
    end
    rd_data_q <= mem_q[rd_ptr_q];
  end

  assign rd_data_o = rd_data_q;
  assign fill_o    = fill_q;

endmodule

`default_nettype wire

### src/bfir_mac.sv
// ----------------------------------------------------------------------------
// bfir_mac: shared multiply-accumulate unit
// One 16x16 signed multiplier with a product register, followed by a
// 32-bit accumulator that wraps. Used once per tap.
// ----------------------------------------------------------------------------
`default_nettype none

module bfir_mac (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bfir_pkg::mac_ctrl_t          ctrl_i,
  input  wire logic [bfir_pkg::DATA_W-1:0]  coef_i,
  input  wire logic [bfir_pkg::DATA_W-1:0]  sample_i,
  output logic                              busy_o,
  output logic [bfir_pkg::DATA_W-1:0]       sum_o
);
  import bfir_pkg::*;

  logic signed [ACC_W-1:0] coef_ext, sample_ext, prod_d;
  logic signed [ACC_W-1:0] prod_q;
  logic                    prod_vld_q;
  logic [ACC_W-1:0]        acc_q;

  // Sign-extend both operands so the product keeps its sign
  assign coef_ext   = ACC_W'(signed'(coef_i));
  assign sample_ext = ACC_W'(signed'(sample_i));
  assign prod_d     = coef_ext * sample_ext;

  // Multiply stage; taps outside the filled region count as zero
  always_ff @(posedge clk_i) begin
    prod_q <= ctrl_i.live ? prod_d : '0;
  end

  // Accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.vld;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(unsigned'(prod_q));
      end
    end
  end

  assign busy_o = prod_vld_q;
  assign sum_o  = acc_q[Q_SHIFT +: DATA_W];

endmodule

`default_nettype wire

### src/banked_fir_filter.sv
// ----------------------------------------------------------------------------
// banked_fir_filter: direct-form Q15 FIR with selectable coefficient banks
// Sample requests run one tap per cycle through a shared multiply-accumulate
// unit; coefficient requests write the coefficient store.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Carries
//  req_i     in   valid / ready    op, sample_in, coef_bank, coef_index,
//                                  coef_value
//  rsp_o     out  valid / ready    sample_out
//  cfg_*     in   cfg_we_i         filter_select (cfg_data_i)
//
//  A coefficient request leaves the sequencer idle; ready stays high.
//  A sample request runs from acceptance to the next acceptance through
//  the accepting cycle, one multiply per tap on the single shared
//  multiplier, a drain of the operand and product registers, then the
//  loading of the result.
//  The result sits in an output register; a stalled result only holds the
//  sequencer once the next result is ready to be loaded.
//  Reset clears the delay line through its fill count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_fir_filter #(
  parameter int unsigned TAPS  = bfir_pkg::DEF_TAPS,
  parameter int unsigned BANKS = bfir_pkg::DEF_BANKS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  bfir_in_if.sink                          req_i,
  bfir_out_if.source                       rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [bfir_pkg::SEL_W-1:0]  cfg_data_i
);
  import bfir_pkg::*;

  localparam int unsigned TAP_W  = $clog2(TAPS);
  localparam int unsigned CNT_W  = $clog2(TAPS+1);
  localparam int unsigned BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned ADDR_W = BANK_W + TAP_W;
  localparam logic [TAP_W-1:0] LAST = TAP_W'(TAPS - 1);

  state_e            state_q, state_d;
  logic [TAP_W-1:0]  cnt_q, cnt_d;
  logic [SEL_W-1:0]  filter_select_q;
  logic              rd_vld_q, rd_live_q;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_data_q;

  logic              req_acc, sample_acc, coef_we, issue, out_load, pipe_empty, sel_ok;
  logic [ADDR_W-1:0] coef_waddr, coef_raddr;
  logic [DATA_W-1:0] coef_rdata, dly_rdata, mac_sum;
  logic [CNT_W-1:0]  fill;
  logic              mac_busy;
  mac_ctrl_t         mac_ctrl;

  // Request decode
  assign req_acc    = req_i.valid && req_i.ready;
  assign sample_acc = req_acc && (req_i.payload.op == OP_SAMPLE);
  assign coef_we    = req_acc && (req_i.payload.op == OP_COEF)
                      && (int'(req_i.payload.coef_bank) < BANKS)
                      && (int'(req_i.payload.coef_index) < TAPS);
  assign coef_waddr = {BANK_W'(req_i.payload.coef_bank), TAP_W'(req_i.payload.coef_index)};
  assign sel_ok     = int'(filter_select_q) < BANKS;
  assign coef_raddr = {BANK_W'(filter_select_q), cnt_q};
  assign pipe_empty = !rd_vld_q && !mac_busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (sample_acc) state_d = ST_MAC;
      ST_MAC:   if (cnt_q == LAST) state_d = ST_DRAIN;
      ST_DRAIN: if (pipe_empty && (!out_vld_q || rsp_o.ready)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE:  req_i.ready = 1'b1;
      ST_MAC:   issue = 1'b1;
      ST_DRAIN: out_load = pipe_empty && (!out_vld_q || rsp_o.ready);
      default:  req_i.ready = 1'b0;
    endcase
  end

  // Tap counter and output valid
  always_comb begin
    cnt_d = cnt_q;
    if (sample_acc) begin
      cnt_d = '0;
    end else if (issue && (cnt_q != LAST)) begin
      cnt_d = cnt_q + 1'b1;
    end
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cnt_q           <= '0;
      filter_select_q <= '0;
      rd_vld_q        <= 1'b0;
      rd_live_q       <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= issue;
      rd_live_q <= issue && sel_ok && (CNT_W'(cnt_q) < fill);
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        filter_select_q <= cfg_data_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_sum;
    end
  end

  assign rsp_o.valid              = out_vld_q;
  assign rsp_o.payload.sample_out = out_data_q;

  assign mac_ctrl.clear = sample_acc;
  assign mac_ctrl.vld   = rd_vld_q;
  assign mac_ctrl.live  = rd_live_q;

  bfir_coef_mem #(
    .ADDR_W (ADDR_W)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (req_i.payload.coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  bfir_delay_line #(
    .TAPS (TAPS)
  ) u_delay_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (sample_acc),
    .push_data_i (req_i.payload.sample_in),
    .step_i      (issue),
    .rd_data_o   (dly_rdata),
    .fill_o      (fill)
  );

  bfir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rdata),
    .sample_i (dly_rdata),
    .busy_o   (mac_busy),
    .sum_o    (mac_sum)
  );

  // A result is only loaded from a drained pipeline
  a_load_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_DRAIN && $past(pipe_empty))
    else $error("result loaded before the pipeline drained");

  // A coefficient request leaves the sequencer idle
  a_coef_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_i.payload.op == OP_COEF) |=> state_q == ST_IDLE)
    else $error("coefficient request started a filter pass");

  // Operand reads only follow an issue cycle
  a_read_follows_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_MAC)
    else $error("operand read without a tap issue");

  // A new sample is never taken while taps are still in flight
  a_no_accept_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_acc |-> pipe_empty)
    else $error("sample accepted while the pipeline is busy");

endmodule

`default_nettype wire

### bench/tb_banked_fir_filter.sv
// ----------------------------------------------------------------------------
// tb_banked_fir_filter: self-checking bench for the banked Q15 FIR filter
// Preloads every coefficient bank, runs a short directed sequence of edge
// samples and tap writes, then random phases under each bank selection.
// A local FIR model predicts each filtered sample. The output channel is
// checked in order against it, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------

module tb_banked_fir_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import bfir_pkg::*;

  localparam int unsigned TAPS         = DEF_TAPS;
  localparam int unsigned BANKS        = DEF_BANKS;
  localparam int unsigned PHASE_ITEMS  = 224;
  localparam int unsigned IDLE_GAP     = TAPS + 16;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [SEL_W-1:0] cfg_data_i;

  bfir_in_if  req_if ();
  bfir_out_if rsp_if ();

  banked_fir_filter #(
    .TAPS  (TAPS),
    .BANKS (BANKS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Model state: delay line, coefficient banks and bank selection
  logic signed [DATA_W-1:0] hist [TAPS];
  logic signed [DATA_W-1:0] coef_mem [BANKS][TAPS];
  logic [SEL_W-1:0]         bank_sel;

  in_req_t           req_q[$];       // requests waiting to be offered
  logic [DATA_W-1:0] filtered_q[$];  // filtered samples awaited on the output

  bit          req_fire;
  int unsigned burst_left, gap_left;
  int unsigned hold_off_reqs, hold_off_done, hold_off_left;
  int unsigned pat_left;
  rx_mode_e    pat_mode;
  int unsigned errors, n_coef, n_samples, n_results, cycles;

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, filtered_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Update the model with one accepted request and queue any filtered sample
  task automatic apply_request(input in_req_t r);
    logic [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0] prod;
    int                      i;
    if (r.op == OP_COEF) begin
      if (r.coef_bank < BANKS && r.coef_index < TAPS)
        coef_mem[r.coef_bank][r.coef_index] = r.coef_value;
    end else begin
      for (i = TAPS - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = r.sample_in;
      acc = '0;
      if (bank_sel < BANKS) begin
        for (i = 0; i < TAPS; i++) begin
          prod = coef_mem[bank_sel][i] * hist[i];
          acc  = acc + prod;
        end
      end
      filtered_q.push_back(acc[Q_SHIFT +: DATA_W]);
    end
  endtask

  // Sample accepted requests at the rising edge
  always @(posedge clk_i) begin
    req_fire = (rst_ni && req_if.valid && req_if.ready) === 1'b1;
    if (req_fire) begin
      if (req_if.payload.op == OP_COEF) n_coef++;
      else n_samples++;
      apply_request(req_if.payload);
    end
  end

  // Driver: offer requests in bursts with random gaps between them
  always @(negedge clk_i) begin : driver
    logic    nxt_valid;
    in_req_t nxt_pay;
    nxt_valid = req_if.valid;
    nxt_pay   = req_if.payload;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (req_fire) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (burst_left > 0) begin
          if (req_q.size() > 0) begin
            nxt_pay   = req_q.pop_front();
            nxt_valid = 1'b1;
            burst_left--;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(30, 1);
        end
      end
    end
    req_if.valid   <= nxt_valid;
    req_if.payload <= nxt_pay;
  end

  // Receiver: a changing ready pattern, with long hold-offs on request
  always @(negedge clk_i) begin : receiver
    logic rdy;
    if (hold_off_left > 0) begin
      hold_off_left--;
      rdy = 1'b0;
    end else if (hold_off_done != hold_off_reqs) begin
      hold_off_done++;
      hold_off_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = rx_mode_e'($urandom_range(3));
        pat_left = $urandom_range(200, 20);
      end
      pat_left--;
      case (pat_mode)
        RX_OPEN:     rdy = 1'b1;
        RX_COIN:     rdy = 1'($urandom_range(1));
        RX_PERIODIC: rdy = (pat_left % 4) != 0;
        default:     rdy = $urandom_range(9) < 2;
      endcase
    end
    rsp_if.ready <= rdy;
  end

  // Monitor: compare each filtered sample with the oldest prediction
  always @(posedge clk_i) begin : monitor
    logic [DATA_W-1:0] want;
    if (rst_ni && (rsp_if.valid && rsp_if.ready) === 1'b1) begin
      n_results++;
      if (filtered_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result %h", $realtime, rsp_if.payload.sample_out);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (rsp_if.payload.sample_out !== want) begin
          if (errors < MAX_REPORTS)
            $display("%0t: sample_out mismatch, expected %h got %h", $realtime, want,
                     rsp_if.payload.sample_out);
          errors++;
        end
      end
    end
  end

  function automatic in_req_t coef_request(input int unsigned bank, input int unsigned idx,
                                           input logic [DATA_W-1:0] value);
    in_req_t r;
    r.op         = OP_COEF;
    r.sample_in  = DATA_W'($urandom);
    r.coef_bank  = SEL_W'(bank);
    r.coef_index = IDX_W'(idx);
    r.coef_value = value;
    return r;
  endfunction

  function automatic in_req_t sample_request(input logic [DATA_W-1:0] value);
    in_req_t r;
    r.op         = OP_SAMPLE;
    r.sample_in  = value;
    r.coef_bank  = SEL_W'($urandom);
    r.coef_index = IDX_W'($urandom);
    r.coef_value = DATA_W'($urandom);
    return r;
  endfunction

  // Mostly samples, some tap rewrites; values lean on full scale and small levels
  function automatic in_req_t random_request();
    int unsigned       pick;
    logic [DATA_W-1:0] value;
    pick = $urandom_range(99);
    if (pick < 10)      value = ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
    else if (pick < 40) value = 16'($urandom_range(511)) - 16'd256;
    else                value = DATA_W'($urandom);
    if ($urandom_range(99) < 25)
      return coef_request($urandom_range(BANKS - 1), $urandom_range(TAPS - 1), value);
    return sample_request(value);
  endfunction

  // Wait until the block has nothing in flight, then let it settle
  task automatic drain_and_idle();
    while (req_q.size() != 0 || req_if.valid || filtered_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic select_bank(input logic [SEL_W-1:0] sel);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= sel;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    bank_sel = sel;
    @(posedge clk_i);
  endtask

  // One random phase under a given bank; optionally hold the output mid-way
  task automatic run_phase(input logic [SEL_W-1:0] sel, input bit with_hold);
    drain_and_idle();
    select_bank(sel);
    repeat (PHASE_ITEMS) req_q.push_back(random_request());
    if (with_hold) begin
      while (req_q.size() > PHASE_ITEMS / 2) @(posedge clk_i);
      hold_off_reqs++;
    end
  endtask

  initial begin
    int unsigned b, i;
    logic [DATA_W-1:0] v;

    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    bank_sel       = '0;
    foreach (hist[k]) hist[k] = '0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Preload every tap of every bank before any sample reads them
    for (b = 0; b < BANKS; b++) begin
      for (i = 0; i < TAPS; i++) begin
        case (b)
          0:       v = 16'h8000;
          1:       v = (i % 2) ? -16'($urandom_range(8191)) : 16'($urandom_range(8191));
          2:       v = DATA_W'($urandom);
          default: v = DATA_W'($urandom_range(2047));
        endcase
        req_q.push_back(coef_request(b, i, v));
      end
    end

    // Directed: full-scale samples against full-scale taps so the sum wraps,
    // unit and zero samples, and tap writes at both ends of the bank
    req_q.push_back(sample_request(16'h8000));
    req_q.push_back(sample_request(16'h8000));
    req_q.push_back(sample_request(16'h8000));
    req_q.push_back(sample_request(16'h8000));
    req_q.push_back(sample_request(16'h7FFF));
    req_q.push_back(sample_request(16'h0000));
    req_q.push_back(sample_request(16'h0001));
    req_q.push_back(sample_request(16'hFFFF));
    req_q.push_back(coef_request(0, 0, 16'h7FFF));
    req_q.push_back(coef_request(0, TAPS - 1, 16'h7FFF));
    req_q.push_back(coef_request(3, TAPS - 1, 16'h8000));
    req_q.push_back(coef_request(2, 0, 16'h7FFF));
    req_q.push_back(coef_request(1, 31, 16'h0000));
    req_q.push_back(sample_request(16'h8000));
    req_q.push_back(sample_request(16'h8000));
    req_q.push_back(sample_request(16'h7FFF));
    req_q.push_back(sample_request(16'h7FFF));
    req_q.push_back(sample_request(16'h0000));

    run_phase(2'd3, 1'b1);
    run_phase(2'd1, 1'b0);
    run_phase(2'd2, 1'b1);
    run_phase(2'd0, 1'b0);
    run_phase(2'd3, 1'b0);

    drain_and_idle();

    $display("Ran %0d tap writes and %0d samples (%0d filtered outputs) across all four banks,",
             n_coef, n_samples, n_results);
    $display("with bursty input, a varying output stall pattern and two long output hold-offs.");
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d outputs missing", errors, filtered_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### banked_fir_filter.f
src/bfir_pkg.sv
src/bfir_in_if.sv
src/bfir_out_if.sv
src/bfir_coef_mem.sv
src/bfir_delay_line.sv
src/bfir_mac.sv
src/banked_fir_filter.sv
bench/tb_banked_fir_filter.sv
